/* design/hnv_pkg.sv */
// shared constants, types and the quarter-wave sine table of the note voice
`default_nettype none

package hnv_pkg;

  // field widths
  localparam int MIX_W   = 24;
  localparam int PHASE_W = 32;
  localparam int AMP_W   = 16;
  localparam int LEN_W   = 24;
  localparam int CFG_W   = 32;
  localparam int POS_BITS = 24;
  localparam int CMP_W   = (POS_BITS > LEN_W) ? POS_BITS : LEN_W;

  // sine table, power-of-two depth, stored as one quarter wave plus its end point
  localparam int SINE_DEPTH = 1024;
  localparam int SINE_ABITS = $clog2(SINE_DEPTH);
  localparam int QTR_BITS   = SINE_ABITS - 2;
  localparam int QTR_DEPTH  = SINE_DEPTH / 4;

  // envelope divider
  localparam int NUM_W     = 44;
  localparam int DEN_W     = 27;
  localparam int Q_W       = 15;
  localparam int DIV_STEPS = Q_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam logic [19:0] ENV_RISE_K = 20'd409600;  // 25 * 32768 / 2
  localparam logic [19:0] ENV_FALL_K = 20'd655360;  // 20 * 32768
  localparam logic [15:0] ENV_ONE    = 16'd32768;

  // partial weights, Q15
  localparam logic [15:0] COEF_H1 = 16'd32768;
  localparam logic [15:0] COEF_H2 = 16'd9175;
  localparam logic [15:0] COEF_H3 = 16'd3932;

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    CFG_PHASE_STEP = 2'd0,
    CFG_AMPLITUDE  = 2'd1,
    CFG_START      = 2'd2,
    CFG_LENGTH     = 2'd3
  } hnv_cfg_reg_e;

  typedef enum logic [1:0] {
    HARM_1 = 2'd0,
    HARM_2 = 2'd1,
    HARM_3 = 2'd2
  } hnv_harm_e;

  typedef enum logic [1:0] {
    ENV_RISE = 2'd0,
    ENV_FALL = 2'd1,
    ENV_FULL = 2'd2
  } hnv_env_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_SETUP = 3'd1,
    ST_RUN   = 3'd2,
    ST_GAIN  = 3'd3,
    ST_PROD  = 3'd4,
    ST_ROUND = 3'd5,
    ST_OUT   = 3'd6
  } hnv_state_e;

  typedef struct packed {
    logic      capture;
    logic      setup;
    logic      pass;
    logic      div_step;
    logic      tab_rd;
    hnv_harm_e tab_sel;
    logic      acc;
    hnv_harm_e acc_sel;
    logic      gain;
    logic      prod;
    logic      round;
    logic      out_load;
  } hnv_cmd_t;

  typedef struct packed {
    logic in_win;
  } hnv_sts_t;

  typedef logic [15:0] qsin_tab_t [QTR_DEPTH+1];

  // sin of r * (pi/2) / 2^30, taylor series to x^13, rounded to q15, floor of zero
  function automatic logic [15:0] quarter_sine(input logic [63:0] r);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        rnd;
    x    = (r * PI_HALF_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + $signed(term);
    if (sum < 0) begin
      sum = 64'sd0;
    end
    rnd = ($unsigned(sum) + 64'd16384) >> 15;
    return rnd[15:0];
  endfunction

  function automatic qsin_tab_t build_qsin();
    qsin_tab_t tab;
    for (int j = 0; j <= QTR_DEPTH; j++) begin
      tab[j] = quarter_sine(64'(j) << (PHASE_W - SINE_ABITS));
    end
    return tab;
  endfunction

  localparam qsin_tab_t QSIN_TABLE = build_qsin();

endpackage

`default_nettype wire

/* design/harmonic_note_voice_top.sv */
// top level of the harmonic note voice: config registers, controller and datapath
`default_nettype none

// One tone voice mixed into a stream of Q4.19 samples. Every sample request on the
// slave side yields exactly one sample on the master side, in order. Positions count
// from the request flagged in tuser (position zero) and wrap at 2^24. Inside the
// window [start_sample, start_sample + note_length) the voice adds amplitude times a
// linear attack/release envelope times the fundamental plus 0.28 of the second and
// 0.12 of the third harmonic, read from a quarter-wave sine table; the sum saturates.
// The phase accumulator is zero at note onset and advances by phase_step per note
// sample. One request is worked on at a time: a sample outside the note goes from
// acceptance through setup straight to the output register, a sample inside passes
// setup, the 15-step restoring divider that forms the envelope, then the gain,
// product and rounding stages. With the output register free the next request is
// taken in the cycle after the sample is loaded into it. A finished sample waits
// in the output register while the next request is accepted and worked on; that
// one then holds until the output register is taken.
// Configuration: cfg_idx_i 0 phase_step, 1 amplitude, 2 start_sample,
// 3 note_length; write only while no request is in flight.

module harmonic_note_voice_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // config write port
  input  wire logic                        cfg_we_i,
  input  wire logic [1:0]                  cfg_idx_i,
  input  wire logic [hnv_pkg::CFG_W-1:0]   cfg_data_i,
  // sample in
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [23:0]                 s_axis_tdata,   // [23:0] mix_in
  input  wire logic                        s_axis_tuser,   // [0] first
  // sample out
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [23:0]                      m_axis_tdata    // [23:0] mix_out
);
  import hnv_pkg::*;

  // configuration registers
  logic [PHASE_W-1:0] phase_step_q;
  logic [AMP_W-1:0]   amplitude_q;
  logic [LEN_W-1:0]   start_q;
  logic [LEN_W-1:0]   length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= '0;
      amplitude_q  <= '0;
      start_q      <= '0;
      length_q     <= '0;
    end else if (cfg_we_i) begin
      case (hnv_cfg_reg_e'(cfg_idx_i))
        CFG_PHASE_STEP: phase_step_q <= cfg_data_i[PHASE_W-1:0];
        CFG_AMPLITUDE:  amplitude_q  <= cfg_data_i[AMP_W-1:0];
        CFG_START:      start_q      <= cfg_data_i[LEN_W-1:0];
        CFG_LENGTH:     length_q     <= cfg_data_i[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // controller and datapath talk only through these
  hnv_cmd_t cmd;
  hnv_sts_t sts;

  hnv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hnv_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .mix_in_i     (s_axis_tdata[MIX_W-1:0]),
    .first_i      (s_axis_tuser),
    .phase_step_i (phase_step_q),
    .amplitude_i  (amplitude_q),
    .start_i      (start_q),
    .length_i     (length_q),
    .mix_out_o    (m_axis_tdata)
  );

endmodule

`default_nettype wire

/* design/hnv_ctrl.sv */
// sequencing state machine of the note voice
`default_nettype none

module hnv_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  input  wire hnv_pkg::hnv_sts_t sts_i,
  output hnv_pkg::hnv_cmd_t      cmd_o
);
  import hnv_pkg::*;

  hnv_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        cnt_d       = '0;
        if (sts_i.in_win) begin
          state_d = ST_RUN;
        end else begin
          cmd_o.pass = 1'b1;
          state_d    = ST_OUT;
        end
      end
      ST_RUN: begin
        // divider runs every cycle, the three partials ride on the first steps
        cmd_o.div_step = 1'b1;
        cmd_o.tab_rd   = (cnt_q < CNT_W'(3));
        cmd_o.tab_sel  = hnv_harm_e'(cnt_q[1:0]);
        cmd_o.acc      = (cnt_q >= CNT_W'(1)) && (cnt_q <= CNT_W'(3));
        cmd_o.acc_sel  = hnv_harm_e'(2'(cnt_q - CNT_W'(1)));
        cnt_d          = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_GAIN;
        end
      end
      ST_GAIN: begin
        cmd_o.gain = 1'b1;
        state_d    = ST_PROD;
      end
      ST_PROD: begin
        cmd_o.prod = 1'b1;
        state_d    = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        state_d     = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* design/hnv_datapath.sv */
// position tracking, envelope divider, partial sum and mixing datapath
`default_nettype none

module hnv_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire hnv_pkg::hnv_cmd_t           cmd_i,
  output hnv_pkg::hnv_sts_t                sts_o,
  input  wire logic [hnv_pkg::MIX_W-1:0]   mix_in_i,
  input  wire logic                        first_i,
  input  wire logic [hnv_pkg::PHASE_W-1:0] phase_step_i,
  input  wire logic [hnv_pkg::AMP_W-1:0]   amplitude_i,
  input  wire logic [hnv_pkg::LEN_W-1:0]   start_i,
  input  wire logic [hnv_pkg::LEN_W-1:0]   length_i,
  output logic [hnv_pkg::MIX_W-1:0]        mix_out_o
);
  import hnv_pkg::*;

  // stream state
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [PHASE_W-1:0]  note_phase_q, note_phase_d;

  // per item payload
  logic signed [MIX_W-1:0]  mix_q;
  logic                     in_win_q;
  logic [LEN_W-1:0]         idx_q;
  logic [PHASE_W-1:0]       ph_q;
  logic [PHASE_W-1:0]       ph3_q;
  hnv_env_e                 env_q;
  logic [DEN_W-1:0]         den_q;
  logic [DEN_W-1:0]         rem_q;
  logic [Q_W-1:0]           num_lo_q;
  logic [Q_W-1:0]           quo_q;
  logic signed [16:0]       sin_q;
  logic signed [31:0]       sum_q;
  logic [AMP_W-1:0]         gain_q;
  logic signed [47:0]       prod_q;
  logic signed [MIX_W-1:0]  res_q;
  logic [MIX_W-1:0]         out_q;

  // capture
  logic [POS_BITS-1:0] pos_now;
  logic [CMP_W-1:0]    pos_w;
  logic [CMP_W-1:0]    start_w;
  logic [CMP_W-1:0]    diff_w;
  logic                in_win;

  assign pos_now = first_i ? '0 : pos_q;
  assign pos_w   = CMP_W'(pos_now);
  assign start_w = CMP_W'(start_i);
  assign diff_w  = pos_w - start_w;
  assign in_win  = (pos_w >= start_w) && (diff_w < CMP_W'(length_i));
  assign pos_d   = pos_now + POS_BITS'(1);

  // setup
  logic [PHASE_W-1:0] ph_sel;
  logic [LEN_W-1:0]   left;
  logic               rise_c;
  logic               fall_c;
  logic [NUM_W-1:0]   num_rise;
  logic [NUM_W-1:0]   num_fall;

  assign ph_sel   = (idx_q == '0) ? '0 : note_phase_q;
  assign left     = length_i - idx_q;
  assign rise_c   = (32'(idx_q) * 32'd100) < (32'(length_i) * 32'd8);
  assign fall_c   = (32'(left) * 32'd20) < (32'(length_i) * 32'd7);
  assign num_rise = NUM_W'(idx_q) * NUM_W'(ENV_RISE_K);
  assign num_fall = NUM_W'(left) * NUM_W'(ENV_FALL_K);

  // divider step
  logic [DEN_W:0] rem_sh;
  logic           qbit;

  assign rem_sh = {rem_q, num_lo_q[Q_W-1]};
  assign qbit   = (rem_sh >= {1'b0, den_q});

  // sine lookup
  logic [PHASE_W-1:0]    tab_ph;
  logic [SINE_ABITS-1:0] tab_k;
  logic [QTR_BITS:0]     tab_j;
  logic [15:0]           tab_mag;
  logic signed [16:0]    tab_val;

  always_comb begin
    case (cmd_i.tab_sel)
      HARM_1:  tab_ph = ph_q;
      HARM_2:  tab_ph = {ph_q[PHASE_W-2:0], 1'b0};
      HARM_3:  tab_ph = ph3_q;
      default: tab_ph = ph_q;
    endcase
  end

  assign tab_k   = tab_ph[PHASE_W-1 -: SINE_ABITS];
  assign tab_j   = tab_k[QTR_BITS] ? ((QTR_BITS+1)'(QTR_DEPTH) - {1'b0, tab_k[QTR_BITS-1:0]})
                                   : {1'b0, tab_k[QTR_BITS-1:0]};
  assign tab_mag = QSIN_TABLE[tab_j];
  assign tab_val = tab_k[SINE_ABITS-1] ? -$signed({1'b0, tab_mag}) : $signed({1'b0, tab_mag});

  // weighted partial
  logic [15:0]        coef;
  logic signed [33:0] acc_prod;

  always_comb begin
    case (cmd_i.acc_sel)
      HARM_1:  coef = COEF_H1;
      HARM_2:  coef = COEF_H2;
      HARM_3:  coef = COEF_H3;
      default: coef = '0;
    endcase
  end

  assign acc_prod = sin_q * $signed({1'b0, coef});

  // gain and rounding
  logic [15:0]            env_val;
  logic [31:0]            gain_full;
  logic signed [48:0]     prod_full;
  logic [47:0]            prod_mag;
  logic [47:0]            prod_rnd;
  logic [21:0]            contrib;
  logic signed [MIX_W+1:0] mix_sum;
  logic signed [MIX_W-1:0] mix_sat;

  assign env_val   = (env_q == ENV_FULL) ? ENV_ONE : {1'b0, quo_q};
  assign gain_full = 32'(amplitude_i) * 32'(env_val);
  assign prod_full = sum_q * $signed({1'b0, gain_q});
  assign prod_mag  = prod_q[47] ? 48'(-prod_q) : 48'(prod_q);
  assign prod_rnd  = prod_mag + 48'(33554432);
  assign contrib   = prod_rnd[47:26];
  assign mix_sum   = prod_q[47] ? ((MIX_W+2)'(mix_q) - $signed({4'b0, contrib}))
                                : ((MIX_W+2)'(mix_q) + $signed({4'b0, contrib}));

  always_comb begin
    if (mix_sum > (MIX_W+2)'(8388607)) begin
      mix_sat = 24'sh7FFFFF;
    end else if (mix_sum < -(MIX_W+2)'(8388608)) begin
      mix_sat = 24'sh800000;
    end else begin
      mix_sat = mix_sum[MIX_W-1:0];
    end
  end

  assign note_phase_d = ph_q + phase_step_i;

  // stream state, reset to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      note_phase_q <= '0;
    end else begin
      if (cmd_i.capture) begin
        pos_q <= pos_d;
      end
      if (cmd_i.round) begin
        note_phase_q <= note_phase_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mix_q    <= $signed(mix_in_i);
      in_win_q <= in_win;
      idx_q    <= diff_w[LEN_W-1:0];
    end
    if (cmd_i.setup) begin
      ph_q  <= ph_sel;
      ph3_q <= ph_sel + {ph_sel[PHASE_W-2:0], 1'b0};
      sum_q <= '0;
      if (rise_c) begin
        env_q    <= ENV_RISE;
        den_q    <= DEN_W'(length_i);
        rem_q    <= num_rise[Q_W +: DEN_W];
        num_lo_q <= num_rise[Q_W-1:0];
      end else if (fall_c) begin
        env_q    <= ENV_FALL;
        den_q    <= DEN_W'(length_i) * DEN_W'(7);
        rem_q    <= num_fall[Q_W +: DEN_W];
        num_lo_q <= num_fall[Q_W-1:0];
      end else begin
        env_q    <= ENV_FULL;
        den_q    <= DEN_W'(length_i);
        rem_q    <= '0;
        num_lo_q <= '0;
      end
    end
    if (cmd_i.div_step) begin
      rem_q    <= qbit ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
      num_lo_q <= {num_lo_q[Q_W-2:0], 1'b0};
      quo_q    <= {quo_q[Q_W-2:0], qbit};
    end
    if (cmd_i.tab_rd) begin
      sin_q <= tab_val;
    end
    if (cmd_i.acc) begin
      sum_q <= sum_q + acc_prod[31:0];
    end
    if (cmd_i.gain) begin
      gain_q <= gain_full[30:15];
    end
    if (cmd_i.prod) begin
      prod_q <= prod_full[47:0];
    end
    if (cmd_i.pass) begin
      res_q <= mix_q;
    end else if (cmd_i.round) begin
      res_q <= mix_sat;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign sts_o.in_win = in_win_q;
  assign mix_out_o    = out_q;

endmodule

`default_nettype wire

/* design/hnv_checker.sv */
// port-level checks of the note voice, bound to the top level
`default_nettype none

module hnv_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata
);

  // requests taken but not yet delivered
  logic [1:0] pend_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output request changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 2'd0)
    else $error("output request with nothing accepted");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> pend_q <= 2'd1)
    else $error("ready while a request is still being worked on");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("ready right after a request was taken");

endmodule

bind harmonic_note_voice_top hnv_checker u_hnv_checker (.*);

`default_nettype wire
